@@ hw/rtl/u8u16_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// u8u16_pkg
// Types and constants shared by the UTF-8 to UTF-16 name decoder modules.
// ----------------------------------------------------------------------------
package u8u16_pkg;

   localparam int UnitCountWidth = 6;
   localparam int JobCountWidth  = 3;

   localparam logic [15:0] ReplacementUnit = 16'hFFFD;
   localparam logic [15:0] BmpLimit        = 16'hFFFF;

   localparam logic [1:0] ContTag = 2'b10;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       end_of_name;
   } req_type;

   typedef struct packed {
      logic [15:0] code_unit;
      logic        last_unit;
   } rsp_type;

   // One queued job: unit_count units, all replacement units except the final
   // one, which carries final_unit and the last mark.
   typedef struct packed {
      logic [JobCountWidth-1:0] unit_count;
      logic [15:0]              final_unit;
      logic                     last_flag;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage : u8u16_pkg
`default_nettype wire

@@ hw/rtl/u8u16_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// u8u16_front
// Accepts bytes, tracks the open UTF-8 sequence and the unit cap, and turns
// each byte into at most one job for the queue.
// ----------------------------------------------------------------------------
module u8u16_front
   import u8u16_pkg::*;
#(
   parameter int MAX_UNITS = 47
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output      logic             req_ready,
   input  wire req_type          req_payload,
   input  wire queue_status_type q_status,
   output      logic             push,
   output      job_type          push_job
);

   localparam logic [UnitCountWidth-1:0] MaxUnits = UnitCountWidth'(MAX_UNITS);

   logic [20:0]               partial_point_ff, partial_point_in;
   logic [1:0]                bytes_needed_ff, bytes_needed_in;
   logic [1:0]                bytes_seen_ff, bytes_seen_in;
   logic [UnitCountWidth-1:0] units_out_ff, units_out_in;
   logic                      capped_ff, capped_in;

   logic                      accept;
   logic [7:0]                b;
   logic                      eon;
   logic                      is_cont;
   logic                      taken;
   logic [JobCountWidth-1:0]  n_units;
   logic [15:0]               tail_unit;
   logic [20:0]               pp_shift;
   logic [1:0]                seen_inc;
   logic [UnitCountWidth-1:0] room;
   logic [JobCountWidth-1:0]  n_emit;
   logic                      cap_hit;

   assign req_ready = !q_status.full;
   assign accept    = req_valid && req_ready;
   assign b         = req_payload.text_byte;
   assign eon       = req_payload.end_of_name;
   assign is_cont   = (b[7:6] == ContTag);
   assign pp_shift  = {partial_point_ff[14:0], b[5:0]};
   assign seen_inc  = bytes_seen_ff + 2'd1;
   assign room      = MaxUnits - units_out_ff;

   // Decode: n_units units, all replacement units but the last, tail_unit.
   always_comb begin
      partial_point_in = partial_point_ff;
      bytes_needed_in  = bytes_needed_ff;
      bytes_seen_in    = bytes_seen_ff;
      n_units          = '0;
      tail_unit        = ReplacementUnit;
      taken            = 1'b0;
      if (bytes_needed_ff != 2'd0) begin
         if (is_cont) begin
            taken = 1'b1;
            if (seen_inc >= bytes_needed_ff) begin
               n_units          = 3'd1;
               tail_unit        = (pp_shift > {5'd0, BmpLimit}) ? ReplacementUnit
                                                                : pp_shift[15:0];
               partial_point_in = '0;
               bytes_needed_in  = '0;
               bytes_seen_in    = '0;
            end else if (eon) begin
               n_units          = 3'd1 + {1'b0, seen_inc};
               partial_point_in = '0;
               bytes_needed_in  = '0;
               bytes_seen_in    = '0;
            end else begin
               partial_point_in = pp_shift;
               bytes_seen_in    = seen_inc;
            end
         end else begin
            // The broken sequence flushes, then this byte starts over.
            n_units          = 3'd1 + {1'b0, bytes_seen_ff};
            partial_point_in = '0;
            bytes_needed_in  = '0;
            bytes_seen_in    = '0;
         end
      end
      if (!taken) begin
         if (b[7] == 1'b0) begin
            n_units   = n_units + 3'd1;
            tail_unit = {8'd0, b};
         end else if (b[7:5] == 3'b110) begin
            partial_point_in = {16'd0, b[4:0]};
            bytes_needed_in  = 2'd1;
         end else if (b[7:4] == 4'b1110) begin
            partial_point_in = {17'd0, b[3:0]};
            bytes_needed_in  = 2'd2;
         end else if (b[7:3] == 5'b11110) begin
            partial_point_in = {18'd0, b[2:0]};
            bytes_needed_in  = 2'd3;
         end else begin
            n_units   = n_units + 3'd1;
            tail_unit = ReplacementUnit;
         end
         if (bytes_needed_in != 2'd0 && eon) begin
            n_units          = n_units + 3'd1;
            tail_unit        = ReplacementUnit;
            partial_point_in = '0;
            bytes_needed_in  = '0;
            bytes_seen_in    = '0;
         end
      end
   end

   // Unit cap.
   always_comb begin
      cap_hit = (n_units != '0) && ({3'd0, n_units} >= room);
      n_emit  = cap_hit ? room[JobCountWidth-1:0] : n_units;

      push                = accept && !capped_ff && (n_units != '0);
      push_job.unit_count = n_emit;
      push_job.final_unit = (n_emit == n_units) ? tail_unit : ReplacementUnit;
      push_job.last_flag  = cap_hit || eon;

      units_out_in = units_out_ff + {3'd0, n_emit};
      capped_in    = capped_ff || cap_hit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_point_ff <= '0;
         bytes_needed_ff  <= '0;
         bytes_seen_ff    <= '0;
         units_out_ff     <= '0;
         capped_ff        <= 1'b0;
      end else if (accept) begin
         if (eon) begin
            partial_point_ff <= '0;
            bytes_needed_ff  <= '0;
            bytes_seen_ff    <= '0;
            units_out_ff     <= '0;
            capped_ff        <= 1'b0;
         end else if (capped_ff || capped_in) begin
            partial_point_ff <= '0;
            bytes_needed_ff  <= '0;
            bytes_seen_ff    <= '0;
            units_out_ff     <= capped_ff ? units_out_ff : units_out_in;
            capped_ff        <= 1'b1;
         end else begin
            partial_point_ff <= partial_point_in;
            bytes_needed_ff  <= bytes_needed_in;
            bytes_seen_ff    <= bytes_seen_in;
            units_out_ff     <= units_out_in;
            capped_ff        <= capped_in;
         end
      end
   end

`ifndef SYNTHESIS
   a_job_count_range: assert property (@(posedge clock) disable iff (reset)
      push |-> (push_job.unit_count != 3'd0 && push_job.unit_count <= 3'd4))
      else $error("job unit count out of range");

   a_no_push_when_capped: assert property (@(posedge clock) disable iff (reset)
      capped_ff |-> !push)
      else $error("job pushed after the unit cap");

   a_units_below_cap: assert property (@(posedge clock) disable iff (reset)
      !capped_ff |-> (units_out_ff < MaxUnits))
      else $error("unit count reached the cap without the capped flag");

   a_seen_below_needed: assert property (@(posedge clock) disable iff (reset)
      (bytes_needed_ff != 2'd0) |-> (bytes_seen_ff < bytes_needed_ff))
      else $error("open sequence has taken all of its bytes");
`endif

endmodule : u8u16_front
`default_nettype wire

@@ hw/rtl/u8u16_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// u8u16_queue
// Short job queue between the decoding front and the unit emitting back.
// ----------------------------------------------------------------------------
module u8u16_queue
   import u8u16_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire job_type          push_job,
   input  wire logic             pop,
   output      job_type          head_job,
   output      queue_status_type q_status
);

   localparam int Depth    = 4;
   localparam int PtrWidth = $clog2(Depth);

   job_type               entries_ff [Depth];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PtrWidth:0]     count_ff, count_in;
   logic                  do_push;
   logic                  do_pop;

   assign q_status.full  = (count_ff == (PtrWidth+1)'(Depth));
   assign q_status.empty = (count_ff == '0);
   assign head_job       = entries_ff[rd_ptr_ff];

   assign do_push   = push && !q_status.full;
   assign do_pop    = pop && !q_status.empty;
   assign wr_ptr_in = wr_ptr_ff + (do_push ? PtrWidth'(1) : PtrWidth'(0));
   assign rd_ptr_in = rd_ptr_ff + (do_pop ? PtrWidth'(1) : PtrWidth'(0));
   assign count_in  = count_ff + {{PtrWidth{1'b0}}, do_push}
                               - {{PtrWidth{1'b0}}, do_pop};

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef SYNTHESIS
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_status.full |-> !push)
      else $error("push into a full queue");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_status.empty |-> !pop)
      else $error("pop from an empty queue");

   a_count_ptrs: assert property (@(posedge clock) disable iff (reset)
      (count_ff[PtrWidth-1:0] == (wr_ptr_ff - rd_ptr_ff)))
      else $error("queue count disagrees with pointers");
`endif

endmodule : u8u16_queue
`default_nettype wire

@@ hw/rtl/u8u16_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// u8u16_back
// Expands queued jobs into code units, one per cycle while the output is
// not stalled, into the output register.
// ----------------------------------------------------------------------------
module u8u16_back
   import u8u16_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire job_type          head_job,
   input  wire queue_status_type q_status,
   output      logic             pop,
   output      logic             rsp_valid,
   input  wire logic             rsp_ready,
   output      rsp_type          rsp_payload
);

   logic [1:0] unit_idx_ff, unit_idx_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_payload_ff, rsp_payload_in;
   logic       load;
   logic       is_final;

   assign load     = !rsp_valid_ff || rsp_ready;
   assign is_final = ({1'b0, unit_idx_ff} == (head_job.unit_count - 3'd1));

   always_comb begin
      pop            = 1'b0;
      unit_idx_in    = unit_idx_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      if (load) begin
         rsp_valid_in = !q_status.empty;
         if (!q_status.empty) begin
            rsp_payload_in.code_unit = is_final ? head_job.final_unit : ReplacementUnit;
            rsp_payload_in.last_unit = is_final && head_job.last_flag;
            pop                      = is_final;
            unit_idx_in              = is_final ? 2'd0 : unit_idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         unit_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         unit_idx_ff  <= unit_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

`ifndef SYNTHESIS
   a_idx_within_job: assert property (@(posedge clock) disable iff (reset)
      !q_status.empty |-> ({1'b0, unit_idx_ff} < head_job.unit_count))
      else $error("unit index beyond the head job");

   a_idx_zero_when_empty: assert property (@(posedge clock) disable iff (reset)
      q_status.empty |-> (unit_idx_ff == 2'd0))
      else $error("unit index left open with no job");

   a_pop_on_final: assert property (@(posedge clock) disable iff (reset)
      pop |=> (rsp_valid_ff && (rsp_payload_ff.last_unit == $past(head_job.last_flag))))
      else $error("final unit of a job lost its mark");
`endif

endmodule : u8u16_back
`default_nettype wire

@@ hw/rtl/utf8_to_utf16_name_decoder_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_to_utf16_name_decoder_unit
// Decodes a UTF-8 name byte stream into UTF-16 code units with replacement
// units for broken sequences and values above the BMP, up to a unit cap.
//
//   Channel  Dir  Handshake            Payload
//   req_     in   req_valid/req_ready  req_type: text_byte, end_of_name
//   rsp_     out  rsp_valid/rsp_ready  rsp_type: code_unit, last_unit
//
// The front takes one byte per cycle while its four-entry job queue has room.
// The back emits one unit per cycle while rsp_ready does not stall it; a byte
// yields k units (k is 0 to 4), and error bursts are absorbed by the queue.
// A byte's first unit passes through the job queue, then the output register.
// Synchronous reset clears decode state, the queue pointers and the output
// valid flag.
// ----------------------------------------------------------------------------
module utf8_to_utf16_name_decoder_unit
   import u8u16_pkg::*;
#(
   parameter int MAX_UNITS = 47
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output      logic    req_ready,
   input  wire req_type req_payload,
   output      logic    rsp_valid,
   input  wire logic    rsp_ready,
   output      rsp_type rsp_payload
);

   queue_status_type q_status;
   logic             push;
   job_type          push_job;
   logic             pop;
   job_type          head_job;

   u8u16_front #(
      .MAX_UNITS (MAX_UNITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .q_status    (q_status),
      .push        (push),
      .push_job    (push_job)
   );

   u8u16_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .q_status (q_status)
   );

   u8u16_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_job    (head_job),
      .q_status    (q_status),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule : utf8_to_utf16_name_decoder_unit
`default_nettype wire

@@ tb/sv/utf8_to_utf16_name_decoder_unit_test.sv @@
// ----------------------------------------------------------------------------
// utf8_to_utf16_name_decoder_unit_test
// Self-checking bench for the UTF-8 to UTF-16 name decoder. A short table of
// hand-picked bytes runs first, then randomly built names: mostly well-formed
// characters with random content, mixed with stray bytes, truncated and broken
// sequences, and a few names long enough to reach the unit cap. A behavioral
// decoder predicts every unit, and each unit leaving the block is compared
// with the oldest prediction. Both channels idle in random bursts.
// ----------------------------------------------------------------------------
module utf8_to_utf16_name_decoder_unit_test
   import u8u16_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CapUnits     = 47;
   localparam int DirectedRows = 25;
   localparam int RandomBytes  = 355;
   localparam int TailCycles   = 12;

   // One row of the directed table. Where pinned is set, the row yields
   // exactly one unit and that unit is typed in by hand.
   typedef struct packed {
      req_type item;
      logic    pinned;
      rsp_type pinned_unit;
   } directed_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_payload;

   // Decoder state of the predictor.
   logic [20:0] seq_point = '0;
   logic [1:0]  seq_need = '0;
   logic [1:0]  seq_seen = '0;
   logic [5:0]  unit_count = '0;
   logic        cap_hit = 1'b0;

   rsp_type    step_units[$];
   rsp_type    expected_units[$];
   logic [7:0] name_bytes[$];
   rsp_type    want_unit;

   int  mismatches = 0;
   int  checked_units = 0;
   int  live_bytes = 0;
   int  dropped_bytes = 0;
   int  names_sent = 0;
   int  cap_names = 0;
   int  stall_left = 0;
   logic calm = 1'b0;

   directed_row_type directed_table [DirectedRows] = '{
      {8'h00, 1'b0, 1'b1, 16'h0000, 1'b0},
      {8'h7F, 1'b1, 1'b1, 16'h007F, 1'b1},
      {8'hE2, 1'b0, 1'b0, 16'h0000, 1'b0},
      {8'h82, 1'b0, 1'b0, 16'h0000, 1'b0},
      {8'hAC, 1'b1, 1'b0, 16'h0000, 1'b0},
      {8'hF0, 1'b0, 1'b0, 16'h0000, 1'b0},
      {8'h9F, 1'b0, 1'b0, 16'h0000, 1'b0},
      {8'h98, 1'b0, 1'b0, 16'h0000, 1'b0},
      {8'h80, 1'b1, 1'b1, ReplacementUnit, 1'b1},
      {8'hED, 1'b0, 1'b0, 16'h0000, 1'b0},
      {8'hA0, 1'b0, 1'b0, 16'h0000, 1'b0},
      {8'h80, 1'b0, 1'b0, 16'h0000, 1'b0},
      {8'hC0, 1'b0, 1'b0, 16'h0000, 1'b0},
      {8'h80, 1'b0, 1'b0, 16'h0000, 1'b0},
      {8'h80, 1'b0, 1'b1, ReplacementUnit, 1'b0},
      {8'hFF, 1'b0, 1'b1, ReplacementUnit, 1'b0},
      {8'hF4, 1'b0, 1'b0, 16'h0000, 1'b0},
      {8'h8F, 1'b0, 1'b0, 16'h0000, 1'b0},
      {8'hBF, 1'b0, 1'b0, 16'h0000, 1'b0},
      {8'h41, 1'b0, 1'b0, 16'h0000, 1'b0},
      {8'hE1, 1'b0, 1'b0, 16'h0000, 1'b0},
      {8'h80, 1'b1, 1'b0, 16'h0000, 1'b0},
      {8'hC2, 1'b1, 1'b1, ReplacementUnit, 1'b1},
      {8'hC2, 1'b0, 1'b0, 16'h0000, 1'b0},
      {8'hE0, 1'b1, 1'b0, 16'h0000, 1'b0}
   };

   utf8_to_utf16_name_decoder_unit #(
      .MAX_UNITS(CapUnits)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_payload(rsp_payload)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic void clear_sequence();
      seq_point = '0;
      seq_need = '0;
      seq_seen = '0;
   endfunction

   function automatic void add_step_unit(input logic [15:0] code);
      rsp_type u;
      u.code_unit = code;
      u.last_unit = 1'b0;
      if (step_units.size() < 4) begin
         step_units.push_back(u);
      end
   endfunction

   // A failed sequence costs one replacement for its lead and one for each
   // continuation byte already taken.
   function automatic void add_error_units();
      int k;
      for (k = 0; k <= int'(seq_seen); k++) begin
         add_step_unit(ReplacementUnit);
      end
      clear_sequence();
   endfunction

   // Works out the units that one byte causes and leaves them in step_units.
   function automatic void decode_byte(input req_type item);
      logic [7:0] b;
      logic       taken;
      int         k;
      b = item.text_byte;
      taken = 1'b0;
      step_units.delete();
      if (cap_hit) begin
         if (item.end_of_name) begin
            clear_sequence();
            unit_count = '0;
            cap_hit = 1'b0;
         end
         return;
      end
      if (seq_need != 0) begin
         if (b[7:6] == ContTag) begin
            seq_point = {seq_point[14:0], b[5:0]};
            seq_seen++;
            if (seq_seen >= seq_need) begin
               add_step_unit(seq_point > 21'(BmpLimit) ? ReplacementUnit : seq_point[15:0]);
               clear_sequence();
            end else if (item.end_of_name) begin
               add_error_units();
            end
            taken = 1'b1;
         end else begin
            add_error_units();
         end
      end
      if (!taken) begin
         if (b[7] == 1'b0) begin
            add_step_unit({8'h00, b});
         end else if (b[7:5] == 3'b110) begin
            seq_point = {16'h0000, b[4:0]};
            seq_need = 2'd1;
         end else if (b[7:4] == 4'b1110) begin
            seq_point = {17'h00000, b[3:0]};
            seq_need = 2'd2;
         end else if (b[7:3] == 5'b11110) begin
            seq_point = {18'h00000, b[2:0]};
            seq_need = 2'd3;
         end else begin
            add_step_unit(ReplacementUnit);
         end
         if (seq_need != 0 && item.end_of_name) begin
            add_error_units();
         end
      end
      for (k = 0; k < step_units.size(); k++) begin
         if (cap_hit) begin
            step_units = step_units[0:k-1];
            break;
         end
         unit_count++;
         step_units[k].last_unit = item.end_of_name && (k == step_units.size() - 1);
         if (int'(unit_count) >= CapUnits) begin
            step_units[k].last_unit = 1'b1;
            cap_hit = 1'b1;
            cap_names++;
            clear_sequence();
         end
      end
      if (item.end_of_name) begin
         clear_sequence();
         unit_count = '0;
         cap_hit = 1'b0;
      end
   endfunction

   // Offers one item, waits for it to be taken, then records what it should
   // produce. A pinned row replaces the prediction with its typed-in unit.
   task automatic send_byte(input req_type item, input logic pinned, input rsp_type pinned_unit);
      int gap;
      if (!calm && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 7);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (!req_ready);
      if (cap_hit) begin
         dropped_bytes++;
      end else begin
         live_bytes++;
      end
      decode_byte(item);
      if (pinned) begin
         expected_units.push_back(pinned_unit);
      end else begin
         foreach (step_units[k]) expected_units.push_back(step_units[k]);
      end
      if (item.end_of_name) begin
         names_sent++;
      end
   endtask

   task automatic hold_until_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_units.size() != 0);
   endtask

   // Result side: check every unit taken, and stall in random bursts.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         checked_units++;
         if (expected_units.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected unit %h last %b", $time,
                     rsp_payload.code_unit, rsp_payload.last_unit);
         end else begin
            want_unit = expected_units.pop_front();
            if (rsp_payload.code_unit !== want_unit.code_unit) begin
               mismatches++;
               $display("%0t: code_unit expected %h got %h", $time,
                        want_unit.code_unit, rsp_payload.code_unit);
            end
            if (rsp_payload.last_unit !== want_unit.last_unit) begin
               mismatches++;
               $display("%0t: last_unit expected %b got %b", $time,
                        want_unit.last_unit, rsp_payload.last_unit);
            end
         end
      end
      if (stall_left != 0) begin
         stall_left--;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(1, 7);
      end
      rsp_ready <= (stall_left == 0);
   end

   initial begin
      int      row;
      int      chars;
      int      c;
      int      seq_len;
      int      conts;
      logic    mid_drain_done;
      logic [7:0] lead;
      req_type item;

      mid_drain_done = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      for (row = 0; row < DirectedRows; row++) begin
         send_byte(directed_table[row].item, directed_table[row].pinned,
                   directed_table[row].pinned_unit);
      end
      hold_until_drained();

      while (live_bytes < RandomBytes) begin
         chars = ($urandom_range(0, 5) == 0) ? $urandom_range(45, 60) : $urandom_range(1, 10);
         name_bytes.delete();
         for (c = 0; c < chars; c++) begin
            seq_len = 0;
            conts = 0;
            case ($urandom_range(0, 9))
               0, 1, 2, 3: name_bytes.push_back(8'($urandom_range(0, 127)));
               4, 5: begin
                  seq_len = 2;
                  conts = 1;
               end
               6: begin
                  seq_len = 3;
                  conts = 2;
               end
               7: begin
                  seq_len = 4;
                  conts = 3;
               end
               8: name_bytes.push_back(8'($urandom_range(0, 255)));
               default: begin
                  // Sequence cut short; the next character breaks it, or the
                  // end mark truncates it.
                  seq_len = $urandom_range(2, 4);
                  conts = $urandom_range(0, seq_len - 2);
               end
            endcase
            if (seq_len != 0) begin
               case (seq_len)
                  2: lead = {3'b110, 5'($urandom)};
                  3: lead = {4'b1110, 4'($urandom)};
                  default: lead = {5'b11110, 3'($urandom)};
               endcase
               name_bytes.push_back(lead);
               repeat (conts) name_bytes.push_back({2'b10, 6'($urandom)});
            end
         end
         foreach (name_bytes[k]) begin
            item.text_byte = name_bytes[k];
            item.end_of_name = (k == name_bytes.size() - 1);
            send_byte(item, 1'b0, '0);
         end
         if (!mid_drain_done && live_bytes >= RandomBytes / 2) begin
            mid_drain_done = 1'b1;
            hold_until_drained();
         end
         if (live_bytes >= (RandomBytes * 4) / 5) begin
            calm = 1'b1;
         end
      end

      hold_until_drained();
      repeat (TailCycles) @(posedge clock);
      $display("Decoded %0d names (%0d bytes, %0d dropped past the cap, %0d capped names);",
               names_sent, live_bytes + dropped_bytes, dropped_bytes, cap_names);
      $display("%0d units checked, %0d mismatches.", checked_units, mismatches);
      if (mismatches == 0 && expected_units.size() == 0) begin
         $display("utf8_to_utf16_name_decoder_unit_test: done, clean");
      end else begin
         $display("utf8_to_utf16_name_decoder_unit_test: done, errors");
      end
      $finish;
   end

   initial begin
      #400000;
      $display("Timed out with %0d units still expected.", expected_units.size());
      $display("utf8_to_utf16_name_decoder_unit_test: done, errors");
      $finish;
   end

endmodule
